@@ hw/rtl/b64d_pkg.sv @@
// Shared types and constants for the strict base64 decoder.
package b64d_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
    localparam logic [1:0] STATUS_BAD_PAD  = 2'd2;
    localparam logic [1:0] STATUS_BAD_LEN  = 2'd3;

    localparam logic [1:0] PAD_LIMIT = 2'd3;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_PAD  = 2'd1,
        KIND_BAD  = 2'd2
    } b64d_kind_t;

    // One classified character as it travels from front to back.
    typedef struct packed {
        logic [5:0] sextet;
        b64d_kind_t kind;
        logic       last;
    } b64d_item_t;

endpackage

@@ hw/rtl/b64d_front.sv @@
// Front end: accepts character beats and classifies them into sextets.
module b64d_front import b64d_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output b64d_item_t out_item
);

    logic       valid_reg;
    logic       valid_next;
    b64d_item_t item_reg;
    b64d_item_t item_next;

    always_comb begin
        item_next.last   = in_last;
        item_next.kind   = KIND_DATA;
        item_next.sextet = 6'd0;
        if (in_char >= 8'h41 && in_char <= 8'h5a) begin
            item_next.sextet = 6'(in_char - 8'h41);
        end else if (in_char >= 8'h61 && in_char <= 8'h7a) begin
            item_next.sextet = 6'(in_char - 8'h47);
        end else if (in_char >= 8'h30 && in_char <= 8'h39) begin
            item_next.sextet = 6'(in_char + 8'h04);
        end else if (in_char == 8'h2b) begin
            item_next.sextet = 6'd62;
        end else if (in_char == 8'h2f) begin
            item_next.sextet = 6'd63;
        end else if (in_char == 8'h3d) begin
            item_next.kind = KIND_PAD;
        end else begin
            item_next.kind = KIND_BAD;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

@@ hw/rtl/b64d_queue.sv @@
// Short queue of classified characters between front and back.
module b64d_queue import b64d_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  b64d_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output b64d_item_t out_item
);

    b64d_item_t entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic push;
    logic pop;

    assign in_ready  = count_reg != QUEUE_CNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                          wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                          rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ hw/rtl/b64d_back.sv @@
// Back end: group assembly, padding and error tracking, result register.
module b64d_back import b64d_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  b64d_item_t  in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [23:0] out_bytes,
    output logic [1:0]  out_count,
    output logic        out_end,
    output logic [1:0]  out_status
);

    logic [1:0]  pos_reg, pos_next;
    logic [17:0] store_reg, store_next;
    logic [1:0]  pad_reg, pad_next;
    logic [1:0]  err_reg, err_next;
    logic        valid_reg, valid_next;
    logic [23:0] bytes_reg, bytes_next;
    logic [1:0]  count_reg, count_next;
    logic        end_reg;
    logic [1:0]  status_reg, status_next;

    logic        take;
    logic        complete;
    logic [23:0] word;
    logic [1:0]  pad_inc;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;
    assign complete = pos_reg == 2'd3;
    assign word     = {store_reg, in_item.sextet};
    assign pad_inc  = (pad_reg == PAD_LIMIT) ? PAD_LIMIT : pad_reg + 2'd1;

    always_comb begin
        pad_next = pad_reg;
        err_next = err_reg;
        if (in_item.kind == KIND_PAD) begin
            pad_next = pad_inc;
            if (pad_inc == PAD_LIMIT && err_reg == STATUS_OK) begin
                err_next = STATUS_BAD_PAD;
            end
        end else if (pad_reg != 2'd0) begin
            // any non-pad character after padding started
            if (err_reg == STATUS_OK) begin
                err_next = STATUS_BAD_PAD;
            end
        end else if (in_item.kind == KIND_BAD) begin
            if (err_reg == STATUS_OK) begin
                err_next = STATUS_BAD_CHAR;
            end
        end

        pos_next   = pos_reg + 2'd1;
        store_next = complete ? 18'd0 : word[17:0];

        count_next = 2'd0;
        bytes_next = 24'd0;
        if (complete && err_next == STATUS_OK && pad_next != PAD_LIMIT) begin
            count_next = 2'd3 - pad_next;
            case (count_next)
                2'd1:    bytes_next = {word[23:16], 16'd0};
                2'd2:    bytes_next = {word[23:8], 8'd0};
                default: bytes_next = word;
            endcase
        end

        status_next = err_next;
        if (in_item.last && pos_next != 2'd0) begin
            status_next = STATUS_BAD_LEN;
            count_next  = 2'd0;
            bytes_next  = 24'd0;
        end

        valid_next = valid_reg && !out_ready;
        if (take) begin
            valid_next = complete || in_item.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 2'd0;
            store_reg <= 18'd0;
            pad_reg   <= 2'd0;
            err_reg   <= STATUS_OK;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (take) begin
                if (in_item.last) begin
                    pos_reg   <= 2'd0;
                    store_reg <= 18'd0;
                    pad_reg   <= 2'd0;
                    err_reg   <= STATUS_OK;
                end else begin
                    pos_reg   <= pos_next;
                    store_reg <= store_next;
                    pad_reg   <= pad_next;
                    err_reg   <= err_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            bytes_reg  <= bytes_next;
            count_reg  <= count_next;
            end_reg    <= in_item.last;
            status_reg <= status_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_bytes  = bytes_reg;
    assign out_count  = count_reg;
    assign out_end    = end_reg;
    assign out_status = status_reg;

endmodule

@@ hw/rtl/strict_base64_decoder.sv @@
// Strict base64 decoder: one character beat in, decoded groups out.
// Path: front register, then the two-entry queue, then the back-end result register.
// Throughput: one character per cycle while the output is not stalled, set by the group and
// padding state update in the back end; a result comes every fourth beat
// and on the last beat of a message.
// Reset: aresetn synchronous active low; clears handshake and group state.
module strict_base64_decoder import b64d_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [23:0] out_bytes, [25:24] out_count, rest 0
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    logic       front_valid;
    logic       front_ready;
    b64d_item_t front_item;
    logic       queue_valid;
    logic       queue_ready;
    b64d_item_t queue_item;
    logic [23:0] res_bytes;
    logic [1:0]  res_count;

    b64d_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_char   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    b64d_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_item  (queue_item)
    );

    b64d_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (queue_valid),
        .in_ready   (queue_ready),
        .in_item    (queue_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_bytes  (res_bytes),
        .out_count  (res_count),
        .out_end    (m_axis_tlast),
        .out_status (m_axis_tuser)
    );

    assign m_axis_tdata = {6'd0, res_count, res_bytes};

endmodule

@@ sim/strict_base64_decoder_test.sv @@
// Self-checking testbench for the strict base64 decoder: random and directed messages.
module strict_base64_decoder_test import b64d_pkg::*; ;

    typedef struct {
        logic [23:0] octets;
        logic [1:0]  count;
        logic        msg_end;
        logic [1:0]  status;
    } group_result_t;

    // Tracks the decoder state and holds the group results still owed.
    class decode_tracker;
        logic [1:0]    quad_pos;
        logic [17:0]   sextet_acc;
        logic [1:0]    pad_seen;
        logic [1:0]    first_err;
        group_result_t pending_groups[$];
        int            failures;
        int            beats_checked;
        int            msgs_ok;
        int            msgs_rejected;

        function new();
            clear();
            failures = 0;
            beats_checked = 0;
            msgs_ok = 0;
            msgs_rejected = 0;
        endfunction

        function void clear();
            quad_pos = '0;
            sextet_acc = '0;
            pad_seen = '0;
            first_err = STATUS_OK;
        endfunction

        function void classify(input logic [7:0] c, output b64d_kind_t kind,
                               output logic [5:0] sext);
            kind = KIND_DATA;
            sext = '0;
            if (c >= "A" && c <= "Z") sext = 6'(c - "A");
            else if (c >= "a" && c <= "z") sext = 6'(c - "a" + 26);
            else if (c >= "0" && c <= "9") sext = 6'(c - "0" + 52);
            else if (c == "+") sext = 6'd62;
            else if (c == "/") sext = 6'd63;
            else if (c == "=") kind = KIND_PAD;
            else kind = KIND_BAD;
        endfunction

        function void note_char(input logic [7:0] c, input logic last_char);
            b64d_kind_t    kind;
            logic [5:0]    sext;
            logic [23:0]   word;
            logic          done;
            group_result_t res;
            classify(c, kind, sext);
            done = 1'b0;
            word = '0;
            if (kind == KIND_PAD) begin
                if (pad_seen != PAD_LIMIT) pad_seen++;
                if (pad_seen == PAD_LIMIT && first_err == STATUS_OK) first_err = STATUS_BAD_PAD;
            end else if (pad_seen != 0) begin
                if (first_err == STATUS_OK) first_err = STATUS_BAD_PAD;
            end else if (kind == KIND_BAD) begin
                if (first_err == STATUS_OK) first_err = STATUS_BAD_CHAR;
            end
            if (quad_pos != 2'd3) begin
                sextet_acc = {sextet_acc[11:0], sext};
                quad_pos++;
            end else begin
                word = {sextet_acc, sext};
                sextet_acc = '0;
                quad_pos = '0;
                done = 1'b1;
            end
            if (!done && !last_char) return;
            res.octets = '0;
            res.count = '0;
            if (done && first_err == STATUS_OK && pad_seen != PAD_LIMIT) begin
                res.count = 2'd3 - pad_seen;
                case (res.count)
                    2'd1:    res.octets = word & 24'hFF0000;
                    2'd2:    res.octets = word & 24'hFFFF00;
                    default: res.octets = word;
                endcase
            end
            res.status = first_err;
            // a partial group at the end outranks every other error
            if (last_char && quad_pos != 0) begin
                res.status = STATUS_BAD_LEN;
                res.count = '0;
                res.octets = '0;
            end
            res.msg_end = last_char;
            pending_groups.push_back(res);
            if (last_char) clear();
        endfunction

        function void check_beat(input logic [31:0] tdata, input logic tlast,
                                 input logic [1:0] tuser);
            group_result_t exp_res;
            if (pending_groups.size() == 0) begin
                $error("result beat with nothing expected: tdata %h tlast %b tuser %0d",
                       tdata, tlast, tuser);
                failures++;
                return;
            end
            exp_res = pending_groups.pop_front();
            beats_checked++;
            if (tdata[23:0] !== exp_res.octets) begin
                $error("out_bytes: expected %h, got %h", exp_res.octets, tdata[23:0]);
                failures++;
            end
            if (tdata[25:24] !== exp_res.count) begin
                $error("out_count: expected %0d, got %0d", exp_res.count, tdata[25:24]);
                failures++;
            end
            if (tdata[31:26] !== 6'd0) begin
                $error("tdata[31:26]: expected 0, got %h", tdata[31:26]);
                failures++;
            end
            if (tlast !== exp_res.msg_end) begin
                $error("message_end: expected %b, got %b", exp_res.msg_end, tlast);
                failures++;
            end
            if (tuser !== exp_res.status) begin
                $error("status: expected %0d, got %0d", exp_res.status, tuser);
                failures++;
            end
            if (exp_res.msg_end) begin
                if (exp_res.status == STATUS_OK) msgs_ok++;
                else msgs_rejected++;
            end
        endfunction

        function int pending();
            return pending_groups.size();
        endfunction
    endclass

    localparam logic [7:0] PAD_CHAR = "=";

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] char_in
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [23:0] out_bytes, [25:24] out_count, rest 0
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;          // [1:0] status

    decode_tracker sb;
    logic [7:0]    msg[$];
    int            burst_left = 0;
    bit            steady = 1'b0;
    int            chars_sent = 0;
    int            msgs_sent = 0;

    strict_base64_decoder DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // values are stable at the falling edge; the beat moves at the next rising edge
    always @(negedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    // receiver: switches between random stall patterns
    initial begin
        int mode;
        int left;
        int tick;
        mode = 0;
        left = 0;
        tick = 0;
        forever begin
            @(posedge aclk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(16, 96);
            end
            left--;
            tick++;
            case (mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (tick % 5) < 2;
            endcase
        end
    end

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        if (v == 62) return "+";
        return "/";
    endfunction

    task automatic push_beat(input logic [7:0] c, input logic last_char);
        logic took;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tlast <= last_char;
        took = 1'b0;
        while (!took) begin
            @(negedge aclk);
            took = s_axis_tready;
            @(posedge aclk);
        end
        sb.note_char(c, last_char);
        chars_sent++;
    endtask

    task automatic send_msg();
        for (int i = 0; i < msg.size(); i++) begin
            if (burst_left == 0) begin
                if (!steady) begin
                    s_axis_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge aclk);
                end
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
            push_beat(msg[i], i == msg.size() - 1);
        end
        msgs_sent++;
        if ($urandom_range(0, 4) == 0) steady = !steady;
    endtask

    task automatic load_text(input string s);
        msg.delete();
        for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
    endtask

    // well-formed encoding of n random bytes; dirty sets the ignored low bits
    task automatic encode_random(input int n, input bit dirty);
        logic [23:0] word;
        int          k;
        msg.delete();
        while (n > 0) begin
            k = (n > 3) ? 3 : n;
            word = 24'($urandom);
            if (k == 1) word[7:0] = '0;
            if (k < 3) word[7:0] = '0;
            if (k == 1) word[15:8] = dirty ? {4'($urandom_range(0, 15)), 4'h0} : 8'h00;
            if (k == 2 && dirty) word[7:6] = 2'($urandom_range(0, 3));
            for (int j = 0; j <= k; j++) msg.push_back(sextet_char(word[23 - 6 * j -: 6]));
            for (int j = k; j < 3; j++) msg.push_back(PAD_CHAR);
            n -= k;
        end
    endtask

    task automatic random_msg();
        int r;
        int pos;
        r = $urandom_range(0, 99);
        encode_random($urandom_range(1, 12), $urandom_range(0, 9) < 3);
        if (r < 55) begin
        end else if (r < 65) begin
            msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (r < 72) begin
            pos = $urandom_range(0, msg.size());
            msg.insert(pos, PAD_CHAR);
        end else if (r < 78) begin
            if (msg.size() > 1) msg.delete($urandom_range(0, msg.size() - 1));
        end else if (r < 83) begin
            msg.push_back($urandom_range(0, 1) ? PAD_CHAR : sextet_char(6'($urandom)));
        end else if (r < 90) begin
            msg.delete();
            repeat ($urandom_range(1, 10)) msg.push_back(8'($urandom_range(0, 255)));
        end else begin
            msg.delete();
            repeat ($urandom_range(1, 12))
                msg.push_back(($urandom_range(0, 4) == 0) ? PAD_CHAR : sextet_char(6'($urandom)));
        end
        send_msg();
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // alphabet edges, one- and two-byte tails, ignored low bits
        load_text("AZaz09+/"); send_msg();
        load_text("TWE="); send_msg();
        load_text("TR=="); send_msg();
        // letter after padding
        load_text("T=Q="); send_msg();
        // good group, then bad char; later bad padding must not replace it
        load_text("TWFu");
        msg.push_back(8'h00);
        msg.push_back(PAD_CHAR);
        msg.push_back("A");
        msg.push_back(8'hFF);
        send_msg();
        // length not a multiple of four
        load_text("AB"); send_msg();

        while (chars_sent < 2000) random_msg();
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Sent %0d messages (%0d characters); %0d result beats checked.",
                 msgs_sent, chars_sent, sb.beats_checked);
        $display("Messages accepted: %0d, rejected with an error status: %0d.",
                 sb.msgs_ok, sb.msgs_rejected);
        if (sb.failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
